/* hw/rtl/sulm_pkg.sv */
// Package for the store unit address and lane merge block.
// Holds the command codes and the request/response word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sulm_pkg;

    typedef enum logic [3:0] {
        CMD_SB  = 4'd0,
        CMD_SH  = 4'd1,
        CMD_SW  = 4'd2,
        CMD_SWL = 4'd3,
        CMD_SWR = 4'd4,
        CMD_SD  = 4'd5,
        CMD_SDL = 4'd6,
        CMD_SDR = 4'd7,
        CMD_SC  = 4'd8,
        CMD_SCD = 4'd9
    } cmd_t;

    localparam logic [63:0] WORD_ALIGN_MASK  = 64'hffff_ffff_ffff_fffc;
    localparam logic [63:0] DWORD_ALIGN_MASK = 64'hffff_ffff_ffff_fff8;

    localparam logic [3:0] BYTES_1 = 4'd1;
    localparam logic [3:0] BYTES_2 = 4'd2;
    localparam logic [3:0] BYTES_4 = 4'd4;
    localparam logic [3:0] BYTES_8 = 4'd8;

    localparam logic [7:0] LANES_1 = 8'h01;
    localparam logic [7:0] LANES_2 = 8'h03;
    localparam logic [7:0] LANES_4 = 8'h0f;
    localparam logic [7:0] LANES_8 = 8'hff;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [63:0]        base_value;
        logic signed [15:0] offset;
        logic [63:0]        store_value;
        logic               link_valid;
        logic [4:0]         dest_index;
    } req_t;

    typedef struct packed {
        logic        mem_write;
        logic [63:0] mem_addr;
        logic [3:0]  access_bytes;
        logic [63:0] write_data;
        logic [7:0]  byte_lanes;
        logic        reg_write;
        logic        reg_value;
    } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/sulm_if.sv */
// Valid/ready channel interfaces for the store unit request and response words.
// Depends on sulm_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sulm_req_if;
    logic           valid;
    logic           ready;
    sulm_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sulm_rsp_if;
    logic           valid;
    logic           ready;
    sulm_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/store_unit_address_and_lane_merge.sv */
// Store unit: effective address, alignment and byte-lane merge for stores.
// Input register, one adder/shifter level, result register; the response word is registered.
// Throughput: one word per cycle unless rsp.ready stalls the output.
// Reset: rst_n clears both stage valid bits asynchronously; payloads are not reset.
// Depends on sulm_pkg and sulm_if.
`timescale 1ns / 1ps
`default_nettype none

module store_unit_address_and_lane_merge (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sulm_req_if.sink     req,
    sulm_rsp_if.source   rsp
);
    import sulm_pkg::*;

    req_t        req_reg;
    logic        req_vld_reg;
    rsp_t        rsp_reg;
    logic        rsp_vld_reg;
    logic        rsp_ready;
    logic        req_ready;
    rsp_t        rsp_next;

    logic [63:0] ea;
    logic [1:0]  b4;
    logic [2:0]  b8;
    logic [63:0] data_raw;
    logic [63:0] lane_mask;

    assign rsp_ready = !rsp_vld_reg || rsp.ready;
    assign req_ready = !req_vld_reg || rsp_ready;

    assign req.ready = req_ready;
    assign rsp.valid = rsp_vld_reg;
    assign rsp.data  = rsp_reg;

    assign ea = req_reg.base_value + {{48{req_reg.offset[15]}}, req_reg.offset};
    assign b4 = ea[1:0];
    assign b8 = ea[2:0];

    always_comb
    begin
        rsp_next = '0;
        data_raw = '0;
        case (req_reg.cmd)
            CMD_SB:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea;
                rsp_next.access_bytes = BYTES_1;
                rsp_next.byte_lanes   = LANES_1;
                data_raw              = req_reg.store_value;
            end
            CMD_SH:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea;
                rsp_next.access_bytes = BYTES_2;
                rsp_next.byte_lanes   = LANES_2;
                data_raw              = req_reg.store_value;
            end
            CMD_SW:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea;
                rsp_next.access_bytes = BYTES_4;
                rsp_next.byte_lanes   = LANES_4;
                data_raw              = req_reg.store_value;
            end
            CMD_SD:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea;
                rsp_next.access_bytes = BYTES_8;
                rsp_next.byte_lanes   = LANES_8;
                data_raw              = req_reg.store_value;
            end
            CMD_SWL:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea & WORD_ALIGN_MASK;
                rsp_next.access_bytes = BYTES_4;
                rsp_next.byte_lanes   = LANES_4 >> b4;
                data_raw = {32'd0, req_reg.store_value[31:0]} >> {b4, 3'b000};
            end
            CMD_SWR:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea & WORD_ALIGN_MASK;
                rsp_next.access_bytes = BYTES_4;
                rsp_next.byte_lanes   = (LANES_4 << ~b4) & LANES_4;
                data_raw              = req_reg.store_value << {~b4, 3'b000};
            end
            CMD_SDL:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea & DWORD_ALIGN_MASK;
                rsp_next.access_bytes = BYTES_8;
                rsp_next.byte_lanes   = LANES_8 >> b8;
                data_raw              = req_reg.store_value >> {b8, 3'b000};
            end
            CMD_SDR:
            begin
                rsp_next.mem_write    = 1'b1;
                rsp_next.mem_addr     = ea & DWORD_ALIGN_MASK;
                rsp_next.access_bytes = BYTES_8;
                rsp_next.byte_lanes   = LANES_8 << ~b8;
                data_raw              = req_reg.store_value << {~b8, 3'b000};
            end
            CMD_SC, CMD_SCD:
            begin
                if (req_reg.link_valid)
                begin
                    rsp_next.mem_write = 1'b1;
                    rsp_next.mem_addr  = ea;
                    data_raw           = req_reg.store_value;
                    if (req_reg.cmd == CMD_SC)
                    begin
                        rsp_next.access_bytes = BYTES_4;
                        rsp_next.byte_lanes   = LANES_4;
                    end
                    else
                    begin
                        rsp_next.access_bytes = BYTES_8;
                        rsp_next.byte_lanes   = LANES_8;
                    end
                    if (req_reg.dest_index != 5'd0)
                    begin
                        rsp_next.reg_write = 1'b1;
                        rsp_next.reg_value = 1'b1;
                    end
                end
                else
                begin
                    rsp_next.reg_write = 1'b1;
                    rsp_next.reg_value = 1'b0;
                end
            end
            default:
            begin
                data_raw = '0;
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            lane_mask[8*i +: 8] = {8{rsp_next.byte_lanes[i]}};
        end
        rsp_next.write_data = data_raw & lane_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_vld_reg <= req.valid;
            end
            if (rsp_ready)
            begin
                rsp_vld_reg <= req_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req.valid)
        begin
            req_reg <= req.data;
        end
        if (rsp_ready && req_vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* sim/store_unit_address_and_lane_merge_tb.sv */
// Testbench for store_unit_address_and_lane_merge: random and directed store words,
// checked against an in-bench predictor of address, size, data, lanes and writeback.
// Depends on sulm_pkg, sulm_if and the store unit RTL.
`timescale 1ns / 1ps

module store_unit_address_and_lane_merge_tb;
    import sulm_pkg::*;

    localparam logic [3:0] CMD_NOP_LO = 4'd10;
    localparam logic [3:0] CMD_NOP_HI = 4'd15;
    localparam int LONG_HOLD_AT = 250;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int BATCHES = 8;
    localparam int BATCH_WORDS = 100;

    logic clk = 1'b0;
    logic rst_n;

    sulm_req_if req_bus ();
    sulm_rsp_if rsp_bus ();

    store_unit_address_and_lane_merge dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    req_t pending_stores[$];
    rsp_t expected_stores[$];
    int   mismatch_count = 0;
    int   responses_seen = 0;
    int   send_gap_left;
    int   recv_stall_left;
    logic long_hold_done;
    logic no_gaps = 1'b0;

    always #10 clk = ~clk;

    function automatic rsp_t predict_store(req_t w);
        rsp_t        r;
        logic [63:0] ea;
        int          b;
        r  = '0;
        ea = w.base_value + {{48{w.offset[15]}}, w.offset};
        case (w.cmd)
            CMD_SB, CMD_SH, CMD_SW, CMD_SD:
            begin
                r.mem_write  = 1'b1;
                r.mem_addr   = ea;
                r.write_data = w.store_value;
                case (w.cmd)
                    CMD_SB:  begin r.access_bytes = BYTES_1; r.byte_lanes = LANES_1; end
                    CMD_SH:  begin r.access_bytes = BYTES_2; r.byte_lanes = LANES_2; end
                    CMD_SW:  begin r.access_bytes = BYTES_4; r.byte_lanes = LANES_4; end
                    default: begin r.access_bytes = BYTES_8; r.byte_lanes = LANES_8; end
                endcase
            end
            CMD_SWL, CMD_SWR:
            begin
                b = int'(ea[1:0]);
                r.mem_write    = 1'b1;
                r.mem_addr     = ea & WORD_ALIGN_MASK;
                r.access_bytes = BYTES_4;
                if (w.cmd == CMD_SWL)
                begin
                    r.write_data = {32'b0, w.store_value[31:0]} >> (8 * b);
                    r.byte_lanes = LANES_4 >> b;
                end
                else
                begin
                    r.write_data = w.store_value << (8 * (3 - b));
                    r.byte_lanes = (LANES_4 << (3 - b)) & LANES_4;
                end
            end
            CMD_SDL, CMD_SDR:
            begin
                b = int'(ea[2:0]);
                r.mem_write    = 1'b1;
                r.mem_addr     = ea & DWORD_ALIGN_MASK;
                r.access_bytes = BYTES_8;
                if (w.cmd == CMD_SDL)
                begin
                    r.write_data = w.store_value >> (8 * b);
                    r.byte_lanes = LANES_8 >> b;
                end
                else
                begin
                    r.write_data = w.store_value << (8 * (7 - b));
                    r.byte_lanes = LANES_8 << (7 - b);
                end
            end
            CMD_SC, CMD_SCD:
            begin
                if (w.link_valid)
                begin
                    r.mem_write    = 1'b1;
                    r.mem_addr     = ea;
                    r.write_data   = w.store_value;
                    r.access_bytes = (w.cmd == CMD_SC) ? BYTES_4 : BYTES_8;
                    r.byte_lanes   = (w.cmd == CMD_SC) ? LANES_4 : LANES_8;
                    r.reg_write    = (w.dest_index != 5'd0);
                    r.reg_value    = (w.dest_index != 5'd0);
                end
                else
                begin
                    r.reg_write = 1'b1;
                    r.reg_value = 1'b0;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            if (!r.byte_lanes[i])
                r.write_data[8*i +: 8] = 8'h00;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic req_t make_store(logic [3:0] c, logic [63:0] base, logic [15:0] off,
                                        logic [63:0] val, logic link, logic [4:0] dest);
        req_t w;
        w.cmd         = c;
        w.base_value  = base;
        w.offset      = off;
        w.store_value = val;
        w.link_valid  = link;
        w.dest_index  = dest;
        return w;
    endfunction

    function automatic req_t random_store();
        req_t w;
        int   roll;
        if ($urandom_range(0, 19) < 18)
            w.cmd = 4'($urandom_range(CMD_SB, CMD_SCD));
        else
            w.cmd = 4'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
        roll = $urandom_range(0, 99);
        if (roll < 70)
            w.base_value = {$urandom, $urandom};
        else if (roll < 85)
            w.base_value = 64'($urandom_range(0, 255));
        else
            w.base_value = 64'hffff_ffff_ffff_ff00 | 64'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 60)
            w.offset = 16'($urandom);
        else if (roll < 80)
            w.offset = 16'($urandom_range(0, 16)) - 16'd8;
        else
            case ($urandom_range(0, 3))
                0:       w.offset = 16'h8000;
                1:       w.offset = 16'h7fff;
                2:       w.offset = 16'hffff;
                default: w.offset = 16'h0000;
            endcase
        roll = $urandom_range(0, 9);
        if (roll < 8)
            w.store_value = {$urandom, $urandom};
        else if (roll == 8)
            w.store_value = '1;
        else
            w.store_value = '0;
        w.link_valid = 1'($urandom_range(0, 1));
        w.dest_index = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < 50)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_store(rsp_t got);
        rsp_t want;
        responses_seen++;
        if (expected_stores.size() == 0)
        begin
            report_mismatch("unexpected word", 64'(got), 64'd0);
            return;
        end
        want = expected_stores.pop_front();
        if (got.mem_write !== want.mem_write)
            report_mismatch("mem_write", 64'(got.mem_write), 64'(want.mem_write));
        if (got.mem_addr !== want.mem_addr)
            report_mismatch("mem_addr", got.mem_addr, want.mem_addr);
        if (got.access_bytes !== want.access_bytes)
            report_mismatch("access_bytes", 64'(got.access_bytes), 64'(want.access_bytes));
        if (got.write_data !== want.write_data)
            report_mismatch("write_data", got.write_data, want.write_data);
        if (got.byte_lanes !== want.byte_lanes)
            report_mismatch("byte_lanes", 64'(got.byte_lanes), 64'(want.byte_lanes));
        if (got.reg_write !== want.reg_write)
            report_mismatch("reg_write", 64'(got.reg_write), 64'(want.reg_write));
        if (got.reg_value !== want.reg_value)
            report_mismatch("reg_value", 64'(got.reg_value), 64'(want.reg_value));
    endtask

    task automatic wait_drained();
        while (pending_stores.size() != 0 || expected_stores.size() != 0 || req_bus.valid)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.data  <= '0;
            send_gap_left <= 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_stores.push_back(predict_store(req_bus.data));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap_left != 0)
                begin
                    req_bus.valid <= 1'b0;
                    send_gap_left <= send_gap_left - 1;
                end
                else if (pending_stores.size() != 0)
                begin
                    req_bus.valid <= 1'b1;
                    req_bus.data  <= pending_stores.pop_front();
                    send_gap_left <= pick_gap();
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready   <= 1'b0;
            recv_stall_left <= 0;
            long_hold_done  <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
                check_store(rsp_bus.data);
            if (!long_hold_done && responses_seen >= LONG_HOLD_AT)
            begin
                long_hold_done  <= 1'b1;
                rsp_bus.ready   <= 1'b0;
                recv_stall_left <= LONG_HOLD_CYCLES;
            end
            else if (recv_stall_left != 0)
            begin
                rsp_bus.ready   <= 1'b0;
                recv_stall_left <= recv_stall_left - 1;
            end
            else
            begin
                rsp_bus.ready   <= 1'b1;
                recv_stall_left <= pick_gap();
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_stores.push_back(make_store(CMD_SB, 64'd0, 16'hffff, '1, 1'b0, 5'd1));
        pending_stores.push_back(make_store(CMD_SH, '1, 16'h0001, 64'h0123_4567_89ab_cdef,
                                            1'b1, 5'd2));
        pending_stores.push_back(make_store(CMD_SW, 64'h1000, 16'h7fff, '1, 1'b0, 5'd3));
        pending_stores.push_back(make_store(CMD_SD, 64'h1000, 16'h8000, '1, 1'b1, 5'd31));
        pending_stores.push_back(make_store(CMD_SWL, 64'h2000, 16'h0000, '1, 1'b0, 5'd4));
        pending_stores.push_back(make_store(CMD_SWL, 64'h2000, 16'h0003,
                                            64'h0123_4567_89ab_cdef, 1'b0, 5'd4));
        pending_stores.push_back(make_store(CMD_SWR, 64'h2000, 16'h0000,
                                            64'h0123_4567_89ab_cdef, 1'b0, 5'd5));
        pending_stores.push_back(make_store(CMD_SWR, 64'h2000, 16'h0003, '1, 1'b1, 5'd5));
        pending_stores.push_back(make_store(CMD_SDL, '1, 16'h0000,
                                            64'h0123_4567_89ab_cdef, 1'b0, 5'd6));
        pending_stores.push_back(make_store(CMD_SDL, 64'h0, 16'h0007, '1, 1'b0, 5'd6));
        pending_stores.push_back(make_store(CMD_SDR, 64'h0, 16'h0000,
                                            64'h0123_4567_89ab_cdef, 1'b0, 5'd7));
        pending_stores.push_back(make_store(CMD_SDR, 64'h0, 16'hffff, '1, 1'b0, 5'd7));
        pending_stores.push_back(make_store(CMD_SC, 64'h3000, 16'h0004, '1, 1'b1, 5'd5));
        pending_stores.push_back(make_store(CMD_SC, 64'h3000, 16'h0004, '1, 1'b1, 5'd0));
        pending_stores.push_back(make_store(CMD_SC, 64'h3000, 16'h0004, '1, 1'b0, 5'd0));
        pending_stores.push_back(make_store(CMD_SCD, '1, 16'h8000, '1, 1'b1, 5'd31));
        pending_stores.push_back(make_store(CMD_SCD, 64'h3000, 16'h7fff, '1, 1'b0, 5'd7));
        pending_stores.push_back(make_store(CMD_NOP_LO, '1, 16'hffff, '1, 1'b1, 5'd31));
        pending_stores.push_back(make_store(CMD_NOP_HI, '1, 16'h7fff, '1, 1'b1, 5'd9));
        wait_drained();

        for (int batch = 0; batch < BATCHES; batch++)
        begin
            no_gaps = (batch == 2 || batch == 5);
            for (int n = 0; n < BATCH_WORDS; n++)
                pending_stores.push_back(random_store());
            if (batch % 2 == 1)
                wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
